// ===== rtl/core/biou_pkg.sv =====
package biou_pkg;

  localparam int unsigned THR_BITS  = 17;
  localparam int unsigned THR_FRAC  = 16;
  localparam logic [THR_BITS-1:0] THR_RESET = 17'd32768;

  typedef struct packed {
    logic above;
    logic enclosed;
    logic fault;
    logic saturate;
  } flags_t;

endpackage

// ===== rtl/core/biou_front.sv =====
module biou_front #(
  parameter int unsigned CB = 12,
  parameter int unsigned FB = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [CB-1:0]         ax_i,
  input  logic signed [CB-1:0]         ay_i,
  input  logic        [CB-2:0]         aw_i,
  input  logic        [CB-2:0]         ah_i,
  input  logic signed [CB-1:0]         bx_i,
  input  logic signed [CB-1:0]         by_i,
  input  logic        [CB-2:0]         bw_i,
  input  logic        [CB-2:0]         bh_i,
  input  logic [biou_pkg::THR_BITS-1:0] thr_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [2*CB-2:0]              rem_o,
  output logic [2*CB-2:0]              div_o,
  output logic [FB+1:0]                feed_o,
  output biou_pkg::flags_t             flags_o
);
  import biou_pkg::*;

  localparam int unsigned DW = 2 * CB - 1;
  localparam int unsigned QW = FB + 2;
  localparam int unsigned PW = THR_BITS + DW;
  localparam int unsigned NS = 5;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? valid_i : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  logic signed [CB:0]   aex, aey, bex, bey;
  logic signed [CB:0]   ex_min, ey_min;
  logic signed [CB-1:0] sx_max, sy_max;
  logic [CB+1:0]        iw_raw, ih_raw;
  logic [CB-1:0]        iw_d, ih_d;
  logic [DW-2:0]        a1_d, a2_d;
  logic                 enc_d;

  always_comb begin
    aex    = $signed({ax_i[CB-1], ax_i}) + $signed({2'b00, aw_i});
    aey    = $signed({ay_i[CB-1], ay_i}) + $signed({2'b00, ah_i});
    bex    = $signed({bx_i[CB-1], bx_i}) + $signed({2'b00, bw_i});
    bey    = $signed({by_i[CB-1], by_i}) + $signed({2'b00, bh_i});
    ex_min = (aex < bex) ? aex : bex;
    ey_min = (aey < bey) ? aey : bey;
    sx_max = (ax_i > bx_i) ? ax_i : bx_i;
    sy_max = (ay_i > by_i) ? ay_i : by_i;
    iw_raw = {ex_min[CB], ex_min} - {{2{sx_max[CB-1]}}, sx_max}
             + {{(CB+1){1'b0}}, 1'b1};
    ih_raw = {ey_min[CB], ey_min} - {{2{sy_max[CB-1]}}, sy_max}
             + {{(CB+1){1'b0}}, 1'b1};
    iw_d   = iw_raw[CB+1] ? '0 : iw_raw[CB-1:0];
    ih_d   = ih_raw[CB+1] ? '0 : ih_raw[CB-1:0];
    a1_d   = (DW-1)'(aw_i) * (DW-1)'(ah_i);
    a2_d   = (DW-1)'(bw_i) * (DW-1)'(bh_i);
    enc_d  = (ax_i <= bx_i) && (ay_i <= by_i) && (aex >= bex) && (aey >= bey);
  end

  logic [DW-2:0] a1_q, a2_q;
  logic [CB-1:0] iw_q, ih_q;
  logic          enc1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a1_q   <= a1_d;
      a2_q   <= a2_d;
      iw_q   <= iw_d;
      ih_q   <= ih_d;
      enc1_q <= enc_d;
    end
  end

  logic [DW-1:0] ii_prod;
  logic [DW-1:0] asum_q, inter2_q;
  logic          enc2_q;

  assign ii_prod = DW'(iw_q) * DW'(ih_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      asum_q   <= {1'b0, a1_q} + {1'b0, a2_q};
      inter2_q <= ii_prod;
      enc2_q   <= enc1_q;
    end
  end

  logic [DW:0]   denom_q;
  logic [DW-1:0] inter3_q;
  logic          enc3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      denom_q  <= {1'b0, asum_q} - {1'b0, inter2_q};
      inter3_q <= inter2_q;
      enc3_q   <= enc2_q;
    end
  end

  logic [DW-1:0] dpos;
  logic          fault_d, sat_d;
  logic [PW-1:0] prod_d;

  always_comb begin
    dpos    = denom_q[DW-1:0];
    fault_d = denom_q[DW] || (denom_q == '0);
    sat_d   = {2'b00, inter3_q} >= {dpos, 2'b00};
    prod_d  = PW'(thr_i) * PW'(dpos);
  end

  logic [PW-1:0] prod4_q;
  logic [DW-1:0] inter4_q, dpos4_q;
  logic          fault4_q, sat4_q, enc4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      prod4_q  <= prod_d;
      inter4_q <= inter3_q;
      dpos4_q  <= dpos;
      fault4_q <= fault_d;
      sat4_q   <= sat_d;
      enc4_q   <= enc3_q;
    end
  end

  logic [PW-1:0] lhs;
  flags_t        flags_d;
  logic [DW-1:0] rem_q, div_q;
  logic [QW-1:0] feed_q;
  flags_t        flags_q;

  always_comb begin
    lhs              = PW'({inter4_q, {THR_FRAC{1'b0}}});
    flags_d.above    = lhs > prod4_q;
    flags_d.enclosed = enc4_q;
    flags_d.fault    = fault4_q;
    flags_d.saturate = sat4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      rem_q   <= inter4_q >> 2;
      div_q   <= dpos4_q;
      feed_q  <= {inter4_q[1:0], {FB{1'b0}}};
      flags_q <= flags_d;
    end
  end

  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign feed_o  = feed_q;
  assign flags_o = flags_q;

`ifndef SYNTH
  a_div_precondition: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && !flags_q.fault && !flags_q.saturate |-> rem_q < div_q)
    else $error("partial remainder not below divisor at divider entry");
  a_fault_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] && en[3] && !denom_q[DW] && denom_q != '0 |=> v_q[3] && !fault4_q)
    else $error("positive denominator flagged as fault");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && !ready_i |=> v_q[NS-1] && $stable(rem_q) && $stable(flags_q))
    else $error("front output changed while stalled");
`endif

endmodule

// ===== rtl/core/biou_div_cell.sv =====
module biou_div_cell #(
  parameter int unsigned DW = 23,
  parameter int unsigned QW = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [DW-1:0]    rem_i,
  input  logic [DW-1:0]    div_i,
  input  logic [QW-1:0]    feed_i,
  input  logic [QW-1:0]    quot_i,
  input  biou_pkg::flags_t flags_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [DW-1:0]    rem_o,
  output logic [DW-1:0]    div_o,
  output logic [QW-1:0]    feed_o,
  output logic [QW-1:0]    quot_o,
  output biou_pkg::flags_t flags_o
);
  import biou_pkg::*;

  logic          v_q;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   diff;
  logic [DW-1:0] rem_d, rem_q, div_q;
  logic [QW-1:0] feed_q, quot_q;
  flags_t        flags_q;

  assign ready_o = !v_q || ready_i;

  always_comb begin
    trial = {rem_i, feed_i[QW-1]};
    ge    = trial >= {1'b0, div_i};
    diff  = trial - {1'b0, div_i};
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      rem_q   <= rem_d;
      div_q   <= div_i;
      feed_q  <= feed_i << 1;
      quot_q  <= {quot_i[QW-2:0], ge};
      flags_q <= flags_i;
    end
  end

  assign valid_o = v_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign feed_o  = feed_q;
  assign quot_o  = quot_q;
  assign flags_o = flags_q;

`ifndef SYNTH
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && !flags_q.fault && !flags_q.saturate |-> rem_q < div_q)
    else $error("remainder not below divisor after step");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && !ready_i |=> v_q && $stable(quot_q) && $stable(rem_q))
    else $error("cell contents changed while stalled");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> v_q)
    else $error("accepted transaction lost in cell");
`endif

endmodule

// ===== rtl/core/box_iou_and_enclosure_top.sv =====
// Box overlap and enclosure unit.
// Input channel (in_valid_i/in_ready_o) takes one pair of boxes per
// transaction, each as top-left corner, width and height. Output channel
// (out_valid_o/out_ready_i) returns one result per pair: overlap ratio in
// unsigned Q2.FRAC_BITS (saturated), a flag for ratio above iou_threshold,
// a flag for the second box lying inside the first, and a fault flag for a
// nonpositive union, which forces ratio and threshold flag to zero.
// The configuration channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the
// 17-bit Q1.16 threshold; it is always ready. Write it only while idle.
// Path from input to output: five geometry and multiply stages, one
// restoring divider cell per quotient bit, and the output register.
// Throughput is one pair per cycle unless the receiver stalls; the divider
// chain retires one quotient bit per cell per cycle under the same condition.
// Reset empties every stage and loads the threshold with 0.5. When the
// receiver stalls, results queue up in the stages; the input keeps being
// accepted until every stage holds a transaction.
module box_iou_and_enclosure_top #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [biou_pkg::THR_BITS-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_BITS-1:0]  first_x_i,
  input  logic signed [COORD_BITS-1:0]  first_y_i,
  input  logic        [COORD_BITS-2:0]  first_width_i,
  input  logic        [COORD_BITS-2:0]  first_height_i,
  input  logic signed [COORD_BITS-1:0]  second_x_i,
  input  logic signed [COORD_BITS-1:0]  second_y_i,
  input  logic        [COORD_BITS-2:0]  second_width_i,
  input  logic        [COORD_BITS-2:0]  second_height_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [FRAC_BITS+1:0]          overlap_ratio_o,
  output logic                          above_threshold_o,
  output logic                          second_enclosed_o,
  output logic                          divide_fault_o
);
  import biou_pkg::*;

  localparam int unsigned DW = 2 * COORD_BITS - 1;
  localparam int unsigned QW = FRAC_BITS + 2;

  logic [THR_BITS-1:0] thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  logic          c_valid [0:QW];
  logic          c_ready [0:QW];
  logic [DW-1:0] c_rem   [0:QW];
  logic [DW-1:0] c_div   [0:QW];
  logic [QW-1:0] c_feed  [0:QW];
  logic [QW-1:0] c_quot  [0:QW];
  flags_t        c_flags [0:QW];

  biou_front #(
    .CB (COORD_BITS),
    .FB (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .ax_i    (first_x_i),
    .ay_i    (first_y_i),
    .aw_i    (first_width_i),
    .ah_i    (first_height_i),
    .bx_i    (second_x_i),
    .by_i    (second_y_i),
    .bw_i    (second_width_i),
    .bh_i    (second_height_i),
    .thr_i   (thr_q),
    .valid_o (c_valid[0]),
    .ready_i (c_ready[0]),
    .rem_o   (c_rem[0]),
    .div_o   (c_div[0]),
    .feed_o  (c_feed[0]),
    .flags_o (c_flags[0])
  );

  assign c_quot[0] = '0;

  for (genvar g = 0; g < QW; g++) begin : g_cell
    biou_div_cell #(
      .DW (DW),
      .QW (QW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[g]),
      .ready_o (c_ready[g]),
      .rem_i   (c_rem[g]),
      .div_i   (c_div[g]),
      .feed_i  (c_feed[g]),
      .quot_i  (c_quot[g]),
      .flags_i (c_flags[g]),
      .valid_o (c_valid[g+1]),
      .ready_i (c_ready[g+1]),
      .rem_o   (c_rem[g+1]),
      .div_o   (c_div[g+1]),
      .feed_o  (c_feed[g+1]),
      .quot_o  (c_quot[g+1]),
      .flags_o (c_flags[g+1])
    );
  end

  logic          out_v_q;
  logic [QW-1:0] ratio_q;
  logic          above_q, enc_q, fault_q;
  flags_t        last_flags;

  assign last_flags  = c_flags[QW];
  assign c_ready[QW] = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (c_ready[QW]) begin
      out_v_q <= c_valid[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready[QW]) begin
      if (last_flags.fault) begin
        ratio_q <= '0;
      end else if (last_flags.saturate) begin
        ratio_q <= '1;
      end else begin
        ratio_q <= c_quot[QW];
      end
      above_q <= last_flags.above && !last_flags.fault;
      enc_q   <= last_flags.enclosed;
      fault_q <= last_flags.fault;
    end
  end

  assign out_valid_o       = out_v_q;
  assign overlap_ratio_o   = ratio_q;
  assign above_threshold_o = above_q;
  assign second_enclosed_o = enc_q;
  assign divide_fault_o    = fault_q;

`ifndef SYNTH
  a_backpressure_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled output");
  a_fault_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_fault_o |-> overlap_ratio_o == '0 && !above_threshold_o)
    else $error("fault result carries a ratio or threshold flag");
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> thr_q == $past(cfg_data_i))
    else $error("threshold register not updated by configuration transaction");
`endif

endmodule

// ===== dv/box_iou_checker.sv =====
module box_iou_checker #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [biou_pkg::THR_BITS-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [COORD_BITS-1:0]  first_x_i,
  input  logic signed [COORD_BITS-1:0]  first_y_i,
  input  logic        [COORD_BITS-2:0]  first_width_i,
  input  logic        [COORD_BITS-2:0]  first_height_i,
  input  logic signed [COORD_BITS-1:0]  second_x_i,
  input  logic signed [COORD_BITS-1:0]  second_y_i,
  input  logic        [COORD_BITS-2:0]  second_width_i,
  input  logic        [COORD_BITS-2:0]  second_height_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [FRAC_BITS+1:0]          overlap_ratio_i,
  input  logic                          above_threshold_i,
  input  logic                          second_enclosed_i,
  input  logic                          divide_fault_i,
  output int                            outstanding_o,
  output int                            mismatch_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FRAC_BITS+1:0] ratio;
    logic                 above;
    logic                 enclosed;
    logic                 fault;
  } overlap_t;

  logic [biou_pkg::THR_BITS-1:0] threshold_q;
  overlap_t                      overlap_q[$];

  function automatic overlap_t predict_overlap(
    input logic signed [COORD_BITS-1:0] ax,
    input logic signed [COORD_BITS-1:0] ay,
    input logic        [COORD_BITS-2:0] aw,
    input logic        [COORD_BITS-2:0] ah,
    input logic signed [COORD_BITS-1:0] bx,
    input logic signed [COORD_BITS-1:0] by,
    input logic        [COORD_BITS-2:0] bw,
    input logic        [COORD_BITS-2:0] bh,
    input logic [biou_pkg::THR_BITS-1:0] thr
  );
    longint   a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1;
    longint   span_x, span_y, inter, denom, quot, top;
    overlap_t res;
    a_x0 = longint'(ax);
    a_y0 = longint'(ay);
    b_x0 = longint'(bx);
    b_y0 = longint'(by);
    a_x1 = a_x0 + longint'(aw);
    a_y1 = a_y0 + longint'(ah);
    b_x1 = b_x0 + longint'(bw);
    b_y1 = b_y0 + longint'(bh);
    span_x = ((a_x1 < b_x1) ? a_x1 : b_x1) - ((a_x0 > b_x0) ? a_x0 : b_x0) + 1;
    span_y = ((a_y1 < b_y1) ? a_y1 : b_y1) - ((a_y0 > b_y0) ? a_y0 : b_y0) + 1;
    if (span_x < 0) span_x = 0;
    if (span_y < 0) span_y = 0;
    inter = span_x * span_y;
    denom = longint'(aw) * longint'(ah) + longint'(bw) * longint'(bh) - inter;
    res = '0;
    if (denom <= 0) begin
      res.fault = 1'b1;
    end else begin
      top  = (longint'(1) << (FRAC_BITS + 2)) - 1;
      quot = (inter << FRAC_BITS) / denom;
      res.ratio = (quot > top) ? top[FRAC_BITS+1:0] : quot[FRAC_BITS+1:0];
      res.above = ((inter << biou_pkg::THR_FRAC) > longint'(thr) * denom);
    end
    res.enclosed = (a_x0 <= b_x0) && (a_y0 <= b_y0) && (a_x1 >= b_x1) && (a_y1 >= b_y1);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count_o++;
  endtask

  initial mismatch_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    overlap_t want;
    overlap_t fresh;
    if (!rst_ni) begin
      threshold_q = biou_pkg::THR_RESET;
      overlap_q.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (overlap_q.size() == 0) begin
          report_mismatch("unexpected transaction, ratio", overlap_ratio_i, 0);
        end else begin
          want = overlap_q.pop_front();
          if (overlap_ratio_i !== want.ratio)
            report_mismatch("overlap_ratio", overlap_ratio_i, want.ratio);
          if (above_threshold_i !== want.above)
            report_mismatch("above_threshold", above_threshold_i, want.above);
          if (second_enclosed_i !== want.enclosed)
            report_mismatch("second_enclosed", second_enclosed_i, want.enclosed);
          if (divide_fault_i !== want.fault)
            report_mismatch("divide_fault", divide_fault_i, want.fault);
        end
      end
      if (in_valid_i && in_ready_i) begin
        fresh = predict_overlap(first_x_i, first_y_i, first_width_i,
                                first_height_i, second_x_i, second_y_i,
                                second_width_i, second_height_i, threshold_q);
        overlap_q = {overlap_q, fresh};
      end
      if (cfg_valid_i && cfg_ready_i) begin
        threshold_q = cfg_data_i;
      end
      outstanding_o <= overlap_q.size();
    end
  end

endmodule

// ===== dv/tb_box_iou_and_enclosure_top.sv =====
module tb_box_iou_and_enclosure_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int          PHASE_ITEMS = 210;
  localparam int          HOLD_AT     = 500;
  localparam int          HOLD_CYCLES = 300;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [biou_pkg::THR_BITS-1:0] cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [COORD_BITS-1:0]  first_x, first_y, second_x, second_y;
  logic        [COORD_BITS-2:0]  first_width, first_height, second_width, second_height;
  logic                          out_valid;
  logic                          out_ready;
  logic [FRAC_BITS+1:0]          overlap_ratio;
  logic                          above_threshold;
  logic                          second_enclosed;
  logic                          divide_fault;
  int                            outstanding;
  int                            mismatches;

  int  items_sent;
  bit  src_calm;

  int directed_pairs [22][8] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 3, 3, 0, 0, 3, 3},
    '{0, 0, 10, 10, 0, 0, 10, 10},
    '{0, 0, 10, 10, 20, 20, 10, 10},
    '{0, 0, 10, 10, 11, 0, 10, 10},
    '{0, 0, 10, 10, 10, 10, 10, 10},
    '{0, 0, 100, 100, 10, 10, 20, 20},
    '{10, 10, 20, 20, 0, 0, 100, 100},
    '{0, 0, 100, 100, 0, 0, 100, 100},
    '{0, 0, 100, 100, -1, 0, 50, 50},
    '{-2048, -2048, 2047, 2047, -2048, -2048, 2047, 2047},
    '{2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047},
    '{-2048, 2047, 0, 2047, 2047, -2048, 2047, 0},
    '{-2048, -2048, 2047, 2047, 2047, 2047, 2047, 2047},
    '{0, 0, 0, 100, 0, 0, 50, 50},
    '{0, 0, 1, 1, 0, 0, 1, 1},
    '{0, 0, 5, 0, 0, 0, 5, 0},
    '{0, 0, 2047, 2047, 1000, 1000, 1, 1},
    '{-1, -1, 2, 2, 0, 0, 2, 2},
    '{0, 0, 4, 4, 1, 1, 4, 4},
    '{100, 100, 2047, 0, 100, 100, 0, 2047},
    '{-2048, 0, 2047, 2047, -1, 0, 2047, 2047}
  };

  box_iou_and_enclosure_top #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .first_x_i        (first_x),
    .first_y_i        (first_y),
    .first_width_i    (first_width),
    .first_height_i   (first_height),
    .second_x_i       (second_x),
    .second_y_i       (second_y),
    .second_width_i   (second_width),
    .second_height_i  (second_height),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .overlap_ratio_o  (overlap_ratio),
    .above_threshold_o(above_threshold),
    .second_enclosed_o(second_enclosed),
    .divide_fault_o   (divide_fault)
  );

  box_iou_checker #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .first_x_i        (first_x),
    .first_y_i        (first_y),
    .first_width_i    (first_width),
    .first_height_i   (first_height),
    .second_x_i       (second_x),
    .second_y_i       (second_y),
    .second_width_i   (second_width),
    .second_height_i  (second_height),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .overlap_ratio_i  (overlap_ratio),
    .above_threshold_i(above_threshold),
    .second_enclosed_i(second_enclosed),
    .divide_fault_i   (divide_fault),
    .outstanding_o    (outstanding),
    .mismatch_count_o (mismatches)
  );

  always #10 clk_i = ~clk_i;

  task automatic send_pair(input int p [8]);
    int gap;
    if (items_sent % 64 == 0) src_calm = ($urandom_range(0, 3) == 0);
    gap = src_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    first_x       <= p[0][COORD_BITS-1:0];
    first_y       <= p[1][COORD_BITS-1:0];
    first_width   <= p[2][COORD_BITS-2:0];
    first_height  <= p[3][COORD_BITS-2:0];
    second_x      <= p[4][COORD_BITS-1:0];
    second_y      <= p[5][COORD_BITS-1:0];
    second_width  <= p[6][COORD_BITS-2:0];
    second_height <= p[7][COORD_BITS-2:0];
    in_valid      <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic make_random_pair(output int p [8]);
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      p[0] = int'($urandom_range(0, 4095)) - 2048;
      p[1] = int'($urandom_range(0, 4095)) - 2048;
      p[2] = $urandom_range(0, 300);
      p[3] = $urandom_range(0, 300);
      p[4] = p[0] + int'($urandom_range(0, 80)) - 40;
      p[5] = p[1] + int'($urandom_range(0, 80)) - 40;
      p[6] = $urandom_range((p[2] > 20) ? p[2] - 20 : 0, p[2] + 20);
      p[7] = $urandom_range((p[3] > 20) ? p[3] - 20 : 0, p[3] + 20);
    end else if (kind < 50) begin
      p[2] = $urandom_range(0, 2047);
      p[3] = $urandom_range(0, 2047);
      p[0] = int'($urandom_range(0, 4095 - p[2])) - 2048;
      p[1] = int'($urandom_range(0, 4095 - p[3])) - 2048;
      p[4] = p[0] + int'($urandom_range(0, p[2]));
      p[5] = p[1] + int'($urandom_range(0, p[3]));
      p[6] = $urandom_range(0, p[0] + p[2] - p[4]);
      p[7] = $urandom_range(0, p[1] + p[3] - p[5]);
      if ($urandom_range(0, 3) == 0) p[6] = p[6] + 1;
      if ($urandom_range(0, 3) == 0) p[5] = p[5] - 1;
    end else if (kind < 65) begin
      p[0] = int'($urandom_range(0, 4095)) - 2048;
      p[1] = int'($urandom_range(0, 4095)) - 2048;
      p[4] = p[0] + int'($urandom_range(0, 6)) - 3;
      p[5] = p[1] + int'($urandom_range(0, 6)) - 3;
      p[2] = $urandom_range(0, 3);
      p[3] = $urandom_range(0, 3);
      p[6] = $urandom_range(0, 3);
      p[7] = $urandom_range(0, 3);
    end else if (kind < 75) begin
      p[0] = $urandom_range(0, 4095);
      p[1] = $urandom_range(0, 4095);
      p[4] = $urandom_range(0, 4095);
      p[5] = $urandom_range(0, 4095);
      p[2] = $urandom_range(1800, 2047);
      p[3] = $urandom_range(1800, 2047);
      p[6] = $urandom_range(1800, 2047);
      p[7] = $urandom_range(1800, 2047);
    end else begin
      p[0] = $urandom_range(0, 4095);
      p[1] = $urandom_range(0, 4095);
      p[4] = $urandom_range(0, 4095);
      p[5] = $urandom_range(0, 4095);
      p[2] = $urandom_range(0, 2047);
      p[3] = $urandom_range(0, 2047);
      p[6] = $urandom_range(0, 2047);
      p[7] = $urandom_range(0, 2047);
    end
  endtask

  task automatic send_random_batch(input int count);
    int p [8];
    repeat (count) begin
      make_random_pair(p);
      send_pair(p);
    end
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input int value);
    cfg_data  <= value[biou_pkg::THR_BITS-1:0];
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int settings [7];
    rst_ni        <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    first_x       <= '0;
    first_y       <= '0;
    first_width   <= '0;
    first_height  <= '0;
    second_x      <= '0;
    second_y      <= '0;
    second_width  <= '0;
    second_height <= '0;
    items_sent = 0;
    src_calm   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_pairs[i]) send_pair(directed_pairs[i]);
    send_random_batch(PHASE_ITEMS);

    settings = '{0, 65536, 131071, 1, int'($urandom_range(0, 65536)),
                 int'($urandom_range(0, 131071)), 32768};
    foreach (settings[k]) begin
      drain_pipeline();
      write_threshold(settings[k]);
      send_random_batch(PHASE_ITEMS);
    end

    drain_pipeline();
    repeat (FRAC_BITS + 24) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("box_iou_and_enclosure_top verification clean");
    end else begin
      $display("box_iou_and_enclosure_top verification failed");
    end
    $finish;
  end

  initial begin : sink
    int  gap;
    int  taken;
    bit  calm;
    taken = 0;
    calm  = 1'b0;
    out_ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 7);
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      taken++;
    end
  end

  initial begin : watchdog
    #5ms;
    $display("box_iou_and_enclosure_top verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/biou_pkg.sv
rtl/core/biou_front.sv
rtl/core/biou_div_cell.sv
rtl/core/box_iou_and_enclosure_top.sv
dv/box_iou_checker.sv
dv/tb_box_iou_and_enclosure_top.sv
